/* rtl/core/ios_pkg.sv */
`default_nettype none

package ios_pkg;

    localparam int FRAC_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam logic [31:0] GAIN_RESET  = 32'h1000_0000;
    localparam logic [31:0] INV_G_Q35   = 32'd3502521750;
    localparam logic [31:0] RAD2DEG_Q26 = 32'd3845054560;

    localparam logic REG_ACCEL_GAIN = 1'b0;
    localparam logic REG_GYRO_GAIN  = 1'b1;

    localparam logic REQ_SAMPLE    = 1'b0;
    localparam logic REQ_CALIBRATE = 1'b1;

    // divide-by-ten unit: reciprocal multiply, ceil(2^40 / 10), two partial products
    localparam int          DIV_W     = 36;
    localparam int          DIV_LO_W  = DIV_W / 2;
    localparam int          DIV_RCP_W = 37;
    localparam int          DIV_SHIFT = 40;
    localparam logic [36:0] DIV_RCP   = 37'd109951162778;

    typedef struct packed {
        logic              req_type;
        logic signed [15:0] accel_x_raw;
        logic signed [15:0] accel_y_raw;
        logic signed [15:0] accel_z_raw;
        logic signed [15:0] gyro_x_raw;
        logic signed [15:0] gyro_y_raw;
        logic signed [15:0] gyro_z_raw;
    } t_in;

    typedef struct packed {
        logic signed [31:0] accel_x_g;
        logic signed [31:0] accel_y_g;
        logic signed [31:0] accel_z_g;
        logic signed [31:0] gyro_x_dps;
        logic signed [31:0] gyro_y_dps;
        logic signed [31:0] gyro_z_dps;
        logic signed [23:0] pitch_deg;
        logic signed [23:0] roll_deg;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MA,
        ST_MB,
        ST_MC,
        ST_MD,
        ST_ME,
        ST_SMOOTH,
        ST_DIV,
        ST_SQUARE,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_CORD_GO,
        ST_CORD_WAIT,
        ST_OUT
    } t_state;

    // atan(2^-i) in degrees, 24 fraction bits
    function automatic logic [31:0] atan_deg(input logic [4:0] idx);
        case (idx)
            5'd0:    return 32'd754974720;
            5'd1:    return 32'd445687602;
            5'd2:    return 32'd235489088;
            5'd3:    return 32'd119537938;
            5'd4:    return 32'd60000934;
            5'd5:    return 32'd30029717;
            5'd6:    return 32'd15018523;
            5'd7:    return 32'd7509720;
            5'd8:    return 32'd3754917;
            5'd9:    return 32'd1877466;
            5'd10:   return 32'd938734;
            5'd11:   return 32'd469367;
            5'd12:   return 32'd234684;
            5'd13:   return 32'd117342;
            5'd14:   return 32'd58671;
            5'd15:   return 32'd29335;
            5'd16:   return 32'd14668;
            5'd17:   return 32'd7334;
            5'd18:   return 32'd3667;
            5'd19:   return 32'd1833;
            5'd20:   return 32'd917;
            5'd21:   return 32'd458;
            5'd22:   return 32'd229;
            5'd23:   return 32'd115;
            default: return 32'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

/* rtl/core/imu_offset_smooth_tilt_unit.sv */
`default_nettype none

// Six-axis IMU front end. A calibrate request (req_type 1) latches the raw
// accel X/Y and gyro X/Y/Z counts as offsets, clears the three accel
// low-pass states and returns nothing. A sample request returns one result:
// offset-corrected, smoothed accel in g, gyro in deg/s and pitch/roll in
// degrees, all with FRAC_BITS fraction bits, saturating. A sample occupies
// the block from acceptance through six scalings, each through states MA to
// ME, on the shared 32x32 multiplier, three filter updates (a setup state
// and a reciprocal divide by ten), the squares of the three accel values,
// per angle a bit-serial square root of 32 steps plus handoff, then
// CORDIC_STEPS vectoring steps (none when y is zero), and an output state
// that waits while an earlier result is still stalled. The input stalls
// while a sample is in flight; a finished result sits in the output
// register and the next request is accepted while it waits. The user must
// write the gains over the APB port only while the block is idle; the
// block itself does not enforce it.
module imu_offset_smooth_tilt_unit #(
    parameter int FRAC_BITS    = ios_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ios_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire ios_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ios_pkg::t_out      o_out,
    input  wire logic          psel,
    input  wire logic          penable,
    input  wire logic          pwrite,
    input  wire logic [2:0]    paddr,
    input  wire logic [31:0]   pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ios_pkg::*;

    localparam int SA = 63 - FRAC_BITS;
    localparam int SG = 54 - FRAC_BITS;
    localparam logic [81:0] HALF_A = 82'(1) << (SA - 1);
    localparam logic [81:0] HALF_G = 82'(1) << (SG - 1);

    t_state r_state;
    t_state n_state;

    logic [31:0]        r_gain_a;
    logic [31:0]        r_gain_g;
    logic signed [15:0] r_off_ax;
    logic signed [15:0] r_off_ay;
    logic signed [15:0] r_off_gx;
    logic signed [15:0] r_off_gy;
    logic signed [15:0] r_off_gz;
    logic signed [31:0] r_sm [3];

    t_in                r_in;
    logic [2:0]         r_idx;
    logic [1:0]         r_cnt;
    logic               r_tilt;
    logic [63:0]        r_prod;
    logic [24:0]        r_mhi;
    logic [81:0]        r_acc;
    logic signed [31:0] r_scaled;
    logic               r_neg;
    logic signed [31:0] r_gdps [3];
    logic [63:0]        r_sq [3];
    logic [31:0]        r_root;
    logic signed [23:0] r_pitch;
    logic signed [23:0] r_roll;
    t_out               r_out;
    logic               r_ovalid;

    logic               in_acc;
    logic               cfg_wr;
    logic               out_free;
    logic               is_gyro;
    logic signed [16:0] diff;
    logic [16:0]        mag;
    logic [31:0]        gain;
    logic [31:0]        kc;
    logic [81:0]        half;
    logic [81:0]        shifted;
    logic signed [31:0] sat_val;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic signed [31:0] sm_old;
    logic signed [35:0] sv;
    logic [35:0]        sv_abs;
    logic signed [31:0] sq_src;
    logic [31:0]        sq_abs;

    logic               div_start;
    logic               div_done;
    logic [DIV_W-1:0]   div_num;
    logic [DIV_W-1:0]   div_quo;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [63:0]        sqrt_n;
    logic [31:0]        sqrt_root;
    logic               cord_start;
    logic               cord_done;
    logic signed [32:0] cord_y;
    logic signed [23:0] cord_ang;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == REG_GYRO_GAIN) ? r_gain_g : r_gain_a;
    assign out_free   = !r_ovalid || !i_out_stall;

    // ---- scaling datapath ----
    assign is_gyro = (r_idx > 3'd2);

    always_comb begin
        case (r_idx)
            3'd0:    diff = {r_in.accel_x_raw[15], r_in.accel_x_raw}
                            - {r_off_ax[15], r_off_ax};
            3'd1:    diff = {r_in.accel_y_raw[15], r_in.accel_y_raw}
                            - {r_off_ay[15], r_off_ay};
            3'd2:    diff = {r_in.accel_z_raw[15], r_in.accel_z_raw};
            3'd3:    diff = {r_in.gyro_x_raw[15], r_in.gyro_x_raw}
                            - {r_off_gx[15], r_off_gx};
            3'd4:    diff = {r_in.gyro_y_raw[15], r_in.gyro_y_raw}
                            - {r_off_gy[15], r_off_gy};
            3'd5:    diff = {r_in.gyro_z_raw[15], r_in.gyro_z_raw}
                            - {r_off_gz[15], r_off_gz};
            default: diff = '0;
        endcase
    end

    assign mag     = diff[16] ? 17'(-diff) : 17'(diff);
    assign gain    = is_gyro ? r_gain_g : r_gain_a;
    assign kc      = is_gyro ? RAD2DEG_Q26 : INV_G_Q35;
    assign half    = is_gyro ? HALF_G : HALF_A;
    assign shifted = is_gyro ? (r_acc >> SG) : (r_acc >> SA);

    always_comb begin
        if (diff[16]) begin
            sat_val = (shifted >= 82'h8000_0000) ? 32'sh8000_0000 : -$signed(shifted[31:0]);
        end else begin
            sat_val = (shifted > 82'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(shifted[31:0]);
        end
    end

    // ---- filter ----
    assign sm_old  = r_sm[r_idx[1:0]];
    assign sv      = 36'(sm_old) * 36'sd7 + 36'(r_scaled) * 36'sd3;
    assign sv_abs  = sv[35] ? 36'(-sv) : 36'(sv);
    assign div_num = sv_abs + 36'd5;

    // ---- squares ----
    always_comb begin
        case (r_cnt)
            2'd0:    sq_src = r_sm[0];
            2'd1:    sq_src = r_sm[1];
            2'd2:    sq_src = r_sm[2];
            default: sq_src = '0;
        endcase
    end

    assign sq_abs = sq_src[31] ? 32'(-sq_src) : 32'(sq_src);

    always_comb begin
        case (r_state)
            ST_MA:     begin mul_a = 32'(mag);           mul_b = gain;   end
            ST_MB:     begin mul_a = 32'(r_prod[23:0]);  mul_b = kc;     end
            ST_MC:     begin mul_a = 32'(r_mhi);         mul_b = kc;     end
            ST_SQUARE: begin mul_a = sq_abs;             mul_b = sq_abs; end
            default:   begin mul_a = '0;                 mul_b = '0;     end
        endcase
    end

    assign sqrt_n = r_tilt ? (r_sq[1] + r_sq[2]) : (r_sq[0] + r_sq[2]);
    assign cord_y = r_tilt ? 33'(r_sm[0]) : -33'(r_sm[1]);

    // ---- sequencer ----
    always_comb begin
        n_state    = r_state;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        cord_start = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && i_in.req_type == REQ_SAMPLE) begin
                    n_state = ST_MA;
                end
            end
            ST_MA: n_state = ST_MB;
            ST_MB: n_state = ST_MC;
            ST_MC: n_state = ST_MD;
            ST_MD: n_state = ST_ME;
            ST_ME: begin
                if (!is_gyro) begin
                    n_state = ST_SMOOTH;
                end else if (r_idx == 3'd5) begin
                    n_state = ST_SQUARE;
                end else begin
                    n_state = ST_MA;
                end
            end
            ST_SMOOTH: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_MA;
                end
            end
            ST_SQUARE: begin
                if (r_cnt == 2'd3) begin
                    n_state = ST_SQRT_GO;
                end
            end
            ST_SQRT_GO: begin
                sqrt_start = 1'b1;
                n_state    = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_state = ST_CORD_GO;
                end
            end
            ST_CORD_GO: begin
                cord_start = 1'b1;
                n_state    = ST_CORD_WAIT;
            end
            ST_CORD_WAIT: begin
                if (cord_done) begin
                    n_state = r_tilt ? ST_OUT : ST_SQRT_GO;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_gain_a <= GAIN_RESET;
            r_gain_g <= GAIN_RESET;
            r_off_ax <= '0;
            r_off_ay <= '0;
            r_off_gx <= '0;
            r_off_gy <= '0;
            r_off_gz <= '0;
            r_sm[0]  <= '0;
            r_sm[1]  <= '0;
            r_sm[2]  <= '0;
            r_idx    <= '0;
            r_cnt    <= '0;
            r_tilt   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (cfg_wr) begin
                if (paddr[2] == REG_GYRO_GAIN) begin
                    r_gain_g <= pwdata;
                end else begin
                    r_gain_a <= pwdata;
                end
            end

            if (in_acc) begin
                r_idx  <= '0;
                r_cnt  <= '0;
                r_tilt <= 1'b0;
                if (i_in.req_type == REQ_CALIBRATE) begin
                    r_off_ax <= i_in.accel_x_raw;
                    r_off_ay <= i_in.accel_y_raw;
                    r_off_gx <= i_in.gyro_x_raw;
                    r_off_gy <= i_in.gyro_y_raw;
                    r_off_gz <= i_in.gyro_z_raw;
                    r_sm[0]  <= '0;
                    r_sm[1]  <= '0;
                    r_sm[2]  <= '0;
                end
            end

            if (r_state == ST_ME && is_gyro) begin
                r_idx <= r_idx + 1'b1;
            end

            if (r_state == ST_DIV && div_done) begin
                r_sm[r_idx[1:0]] <= r_neg ? -$signed(div_quo[31:0]) : $signed(div_quo[31:0]);
                r_idx <= r_idx + 1'b1;
            end

            if (r_state == ST_SQUARE) begin
                r_cnt <= r_cnt + 1'b1;
            end

            if (r_state == ST_CORD_WAIT && cord_done) begin
                r_tilt <= 1'b1;
            end

            if (r_state == ST_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(mul_a) * 64'(mul_b);

        if (in_acc) begin
            r_in <= i_in;
        end

        case (r_state)
            ST_MB: r_mhi <= r_prod[48:24];
            ST_MC: r_acc <= 82'(r_prod) + half;
            ST_MD: r_acc <= r_acc + (82'(r_prod) << 24);
            ST_ME: begin
                r_scaled <= sat_val;
                if (is_gyro) begin
                    r_gdps[2'(r_idx - 3'd3)] <= sat_val;
                end
            end
            ST_SMOOTH: r_neg <= sv[35];
            ST_SQUARE: begin
                if (r_cnt != 2'd0) begin
                    r_sq[r_cnt - 2'd1] <= r_prod;
                end
            end
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    r_root <= sqrt_root;
                end
            end
            ST_CORD_WAIT: begin
                if (cord_done) begin
                    if (r_tilt) begin
                        r_roll <= cord_ang;
                    end else begin
                        r_pitch <= cord_ang;
                    end
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    r_out.accel_x_g  <= r_sm[0];
                    r_out.accel_y_g  <= r_sm[1];
                    r_out.accel_z_g  <= r_sm[2];
                    r_out.gyro_x_dps <= r_gdps[0];
                    r_out.gyro_y_dps <= r_gdps[1];
                    r_out.gyro_z_dps <= r_gdps[2];
                    r_out.pitch_deg  <= r_pitch;
                    r_out.roll_deg   <= r_roll;
                end
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    ios_div10 u_div10 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    ios_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_n     (sqrt_n),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    ios_cordic #(
        .FRAC_BITS    (FRAC_BITS),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (cord_start),
        .i_y     (cord_y),
        .i_x     (r_root),
        .o_done  (cord_done),
        .o_angle (cord_ang)
    );

endmodule

`default_nettype wire

/* rtl/core/ios_div10.sv */
`default_nettype none

module ios_div10 (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ios_pkg::DIV_W-1:0] i_num,
    output logic                           o_done,
    output logic [ios_pkg::DIV_W-1:0]      o_quo
);
    import ios_pkg::*;

    localparam int PW = DIV_LO_W + DIV_RCP_W;
    localparam int AW = DIV_W + DIV_RCP_W;

    logic [DIV_W-1:0]    r_num;
    logic [AW-1:0]       r_acc;
    logic                r_busy;
    logic                r_phase;
    logic                r_done;

    logic [DIV_LO_W-1:0] mul_a;
    logic [PW-1:0]       prod;

    // low half first, then high half shifted in
    assign mul_a = r_phase ? r_num[DIV_W-1:DIV_LO_W] : r_num[DIV_LO_W-1:0];
    assign prod  = PW'(mul_a) * PW'(DIV_RCP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_phase <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_phase <= 1'b0;
            end else if (r_busy) begin
                if (r_phase) begin
                    r_busy  <= 1'b0;
                    r_phase <= 1'b0;
                    r_done  <= 1'b1;
                end else begin
                    r_phase <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
        end else if (r_busy) begin
            if (r_phase) begin
                r_acc <= r_acc + (AW'(prod) << DIV_LO_W);
            end else begin
                r_acc <= AW'(prod);
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = DIV_W'(r_acc[AW-1:DIV_SHIFT]);

endmodule

`default_nettype wire

/* rtl/core/ios_sqrt.sv */
`default_nettype none

module ios_sqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_n,
    output logic             o_done,
    output logic [31:0]      o_root
);
    logic [63:0] r_n;
    logic [63:0] r_root;
    logic [63:0] r_bit;
    logic        r_busy;
    logic        r_done;

    logic [63:0] trial;

    assign trial = r_root + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n    <= i_n;
            r_root <= '0;
            r_bit  <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (r_n >= trial) begin
                r_n    <= r_n - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_root[31:0];

endmodule

`default_nettype wire

/* rtl/core/ios_cordic.sv */
`default_nettype none

module ios_cordic #(
    parameter int FRAC_BITS    = ios_pkg::FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = ios_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [32:0] i_y,
    input  wire logic [31:0]        i_x,
    output logic                    o_done,
    output logic signed [23:0]      o_angle
);
    import ios_pkg::*;

    localparam int      CW      = $clog2(CORDIC_STEPS + 1);
    localparam longint  LIM_RAW = longint'(90) << FRAC_BITS;
    localparam longint  LIM     = (LIM_RAW > 64'sh7F_FFFF) ? 64'sh7F_FFFF : LIM_RAW;
    localparam logic signed [32:0] LIM_Z = 33'(LIM);

    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic signed [32:0] r_z;
    logic [CW-1:0]      r_i;
    logic               r_busy;
    logic               r_fin;
    logic               r_done;
    logic signed [23:0] r_ang;

    logic signed [35:0] c_dx;
    logic signed [35:0] c_dy;
    logic signed [32:0] c_at;
    logic signed [32:0] z_rnd;
    logic signed [32:0] z_clip;

    assign c_dx = r_y >>> r_i;
    assign c_dy = r_x >>> r_i;
    assign c_at = $signed({1'b0, atan_deg(5'(r_i))});

    generate
        if (FRAC_BITS < 24) begin : g_round
            localparam int RS = 24 - FRAC_BITS;
            assign z_rnd = (r_z + (33'sd1 <<< (RS - 1))) >>> RS;
        end else begin : g_noround
            assign z_rnd = r_z;
        end
    endgenerate

    always_comb begin
        if (z_rnd > LIM_Z) begin
            z_clip = LIM_Z;
        end else if (z_rnd < -LIM_Z) begin
            z_clip = -LIM_Z;
        end else begin
            z_clip = z_rnd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_start) begin
                r_i <= '0;
                if (i_y == 33'sd0) begin
                    r_fin <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_i <= r_i + 1'b1;
                if (r_i == CW'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end else if (r_fin) begin
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= $signed({4'b0, i_x});
            r_y <= 36'(i_y);
            r_z <= '0;
        end else if (r_busy) begin
            if (r_y > 36'sd0) begin
                r_x <= r_x + c_dx;
                r_y <= r_y - c_dy;
                r_z <= r_z + c_at;
            end else begin
                r_x <= r_x - c_dx;
                r_y <= r_y + c_dy;
                r_z <= r_z - c_at;
            end
        end
        if (r_fin) begin
            r_ang <= z_clip[23:0];
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_ang;

endmodule

`default_nettype wire
